// File: sv/psk_pkg.sv
`default_nettype none
package psk_pkg;

  localparam int FIELD_W   = 24;
  localparam int TGT_W     = 23;
  localparam int NUM_GRP   = 4;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;

  // register index layout: bit 0 picks y over x, bits 2:1 pick the group
  localparam int CFG_AXIS_BIT = 0;

  // target reset points in whole pixels, shifted up by the fraction width at reset
  localparam logic [11:0] TGT_RESET_X_PX [NUM_GRP] = '{12'd1640, 12'd2680, 12'd1640, 12'd2680};
  localparam logic [11:0] TGT_RESET_Y_PX [NUM_GRP] = '{12'd192, 12'd192, 12'd1728, 12'd1728};

  typedef struct packed {
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] vel_x;
    logic signed [FIELD_W-1:0] vel_y;
    logic                      hidden;
    logic [1:0]                group;
  } psk_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] new_pos_x;
    logic signed [FIELD_W-1:0] new_pos_y;
    logic signed [FIELD_W-1:0] new_vel_x;
    logic signed [FIELD_W-1:0] new_vel_y;
    logic                      new_hidden;
  } psk_out_t;

endpackage
`default_nettype wire

// File: sv/psk_ifs.sv
`default_nettype none
interface psk_in_if;
  import psk_pkg::*;
  logic    valid;
  logic    ready;
  psk_in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface psk_out_if;
  import psk_pkg::*;
  logic     valid;
  logic     ready;
  psk_out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/particle_seek_target_step.sv
// channel   dir  handshake     payload
// in_ch     in   valid/ready   pos_x pos_y vel_x vel_y hidden group
// out_ch    out  valid/ready   new_pos_x new_pos_y new_vel_x new_vel_y new_hidden
// cfg       in   cfg_we        cfg_idx, cfg_data (target x/y per group)
//
// one item per cycle while the skid register is empty; 60 register stages
// (9 arithmetic stages, two 31-stage square roots side by side, two 19-stage dividers
// side by side, output register).
// synchronous reset clears the valid bits and loads the default targets.
// a stalled output parks the next result in a skid register; input is refused
// only while the skid register is full, and the whole pipeline holds with it.
`default_nettype none
module particle_seek_target_step #(
  parameter int FRAC_BITS = 10
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [psk_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [psk_pkg::TGT_W-1:0]       cfg_data,
  psk_in_if.sink                               in_ch,
  psk_out_if.source                            out_ch
);
  import psk_pkg::*;

  localparam int SQ_W   = 62;
  localparam int SQ_LAT = SQ_W / 2;
  localparam int DV_LAT = 19;
  localparam int NV     = 9 + SQ_LAT + DV_LAT;
  localparam logic [49:0] HIDE_D2 = 50'(49) << (2 * FRAC_BITS);

  typedef struct packed {
    logic signed [FIELD_W-1:0] px;
    logic signed [FIELD_W-1:0] py;
    logic signed [FIELD_W-1:0] vx;
    logic signed [FIELD_W-1:0] vy;
    logic                      hid;
    logic [TGT_W-1:0]          tx;
    logic [TGT_W-1:0]          ty;
    logic                      near;
    logic                      zero;
    logic                      sx;
    logic                      sy;
    logic [29:0]               abxn;
    logic [29:0]               abyn;
  } sb_t;

  function automatic logic signed [FIELD_W-1:0] sat24(logic signed [FIELD_W:0] v);
    if (v > 25'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -25'sd8388608) begin
      return 24'sh800000;
    end
    return v[FIELD_W-1:0];
  endfunction

  // target registers
  logic [TGT_W-1:0] tgt_x [NUM_GRP];
  logic [TGT_W-1:0] tgt_y [NUM_GRP];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < NUM_GRP; g++) begin
        tgt_x[g] <= TGT_W'(32'(TGT_RESET_X_PX[g]) << FRAC_BITS);
        tgt_y[g] <= TGT_W'(32'(TGT_RESET_Y_PX[g]) << FRAC_BITS);
      end
    end else if (cfg_we && (cfg_idx < CFG_IDX_W'(NUM_REGS))) begin
      if (cfg_idx[CFG_AXIS_BIT]) begin
        tgt_y[cfg_idx[2:1]] <= cfg_data;
      end else begin
        tgt_x[cfg_idx[2:1]] <= cfg_data;
      end
    end
  end

  // handshake and valid chain
  logic          en;
  logic          skid_vld;
  logic [NV-1:0] vld;
  logic          in_acc;

  assign en          = !skid_vld;
  assign in_ch.ready = en;
  assign in_acc      = in_ch.valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-2:0], in_acc};
    end
  end

  // stage 1: target lookup and offsets
  logic [TGT_W-1:0]   tx_in, ty_in;
  sb_t                sb1, sb1_next;
  logic signed [24:0] dx1, dy1;

  assign tx_in = tgt_x[in_ch.data.group];
  assign ty_in = tgt_y[in_ch.data.group];

  always_comb begin
    sb1_next     = '0;
    sb1_next.px  = in_ch.data.pos_x;
    sb1_next.py  = in_ch.data.pos_y;
    sb1_next.vx  = in_ch.data.vel_x;
    sb1_next.vy  = in_ch.data.vel_y;
    sb1_next.hid = in_ch.data.hidden;
    sb1_next.tx  = tx_in;
    sb1_next.ty  = ty_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb1 <= sb1_next;
      dx1 <= $signed({2'b00, tx_in}) - 25'(in_ch.data.pos_x);
      dy1 <= $signed({2'b00, ty_in}) - 25'(in_ch.data.pos_y);
    end
  end

  // stage 2: squared offsets and blend 990*v + d
  sb_t                sb2;
  logic [24:0]        adx, ady;
  logic [49:0]        adx2, ady2;
  logic signed [35:0] bx2, by2;

  assign adx = dx1[24] ? 25'(-dx1) : 25'(dx1);
  assign ady = dy1[24] ? 25'(-dy1) : 25'(dy1);

  always_ff @(posedge clk) begin
    if (en) begin
      sb2  <= sb1;
      adx2 <= 50'(adx) * 50'(adx);
      ady2 <= 50'(ady) * 50'(ady);
      bx2  <= 36'(sb1.vx) * 36'sd990 + 36'(dx1);
      by2  <= 36'(sb1.vy) * 36'sd990 + 36'(dy1);
    end
  end

  // stage 3: distance squared and blend magnitudes
  sb_t         sb3, sb3_next;
  logic [49:0] d2_3;
  logic [34:0] abx3, aby3;

  always_comb begin
    sb3_next    = sb2;
    sb3_next.sx = bx2[35];
    sb3_next.sy = by2[35];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb3    <= sb3_next;
      d2_3   <= adx2 + ady2;
      abx3   <= bx2[35] ? 35'(-bx2) : 35'(bx2);
      aby3   <= by2[35] ? 35'(-by2) : 35'(by2);
    end
  end

  // stage 4: leading one of the larger magnitude, hide test
  sb_t         sb4, sb4_next;
  logic [49:0] d2_4;
  logic [34:0] abx4, aby4;
  logic [5:0]  top3, top4;
  logic [34:0] m3;

  assign m3 = abx3 | aby3;

  always_comb begin
    top3 = '0;
    for (int k = 0; k < 35; k++) begin
      if (m3[k]) begin
        top3 = 6'(k);
      end
    end
  end

  always_comb begin
    sb4_next      = sb3;
    sb4_next.near = d2_3 < HIDE_D2;
    sb4_next.zero = m3 == '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb4      <= sb4_next;
      d2_4     <= d2_3;
      abx4     <= abx3;
      aby4     <= aby3;
      top4     <= top3;
    end
  end

  // stage 5: common shift so the larger magnitude tops out at bit 29
  sb_t         sb5, sb5_next;
  logic [49:0] d2_5;
  logic [34:0] abx_sh, aby_sh;

  always_comb begin
    if (top4 >= 6'd29) begin
      abx_sh = abx4 >> (top4 - 6'd29);
      aby_sh = aby4 >> (top4 - 6'd29);
    end else begin
      abx_sh = abx4 << (6'd29 - top4);
      aby_sh = aby4 << (6'd29 - top4);
    end
    sb5_next      = sb4;
    sb5_next.abxn = abx_sh[29:0];
    sb5_next.abyn = aby_sh[29:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb5      <= sb5_next;
      d2_5     <= d2_4;
    end
  end

  // stage 6 and 7: squared length of the shifted blend
  sb_t         sb6, sb7;
  logic [49:0] d2_6, d2_7;
  logic [59:0] sqx6, sqy6;
  logic [60:0] ssum7;

  always_ff @(posedge clk) begin
    if (en) begin
      sb6   <= sb5;
      d2_6  <= d2_5;
      sqx6  <= 60'(sb5.abxn) * 60'(sb5.abxn);
      sqy6  <= 60'(sb5.abyn) * 60'(sb5.abyn);
      sb7   <= sb6;
      d2_7  <= d2_6;
      ssum7 <= 61'(sqx6) + 61'(sqy6);
    end
  end

  // square roots: distance and blend length
  logic [SQ_LAT-1:0] dist_root, len_root;

  psk_isqrt #(.W(SQ_W)) u_sqrt_dist (
    .clk  (clk),
    .en   (en),
    .rad  (SQ_W'(d2_7)),
    .root (dist_root)
  );

  psk_isqrt #(.W(SQ_W)) u_sqrt_len (
    .clk  (clk),
    .en   (en),
    .rad  (SQ_W'(ssum7)),
    .root (len_root)
  );

  sb_t sq_sb [SQ_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_LAT; k++) begin
        sq_sb[k] <= (k == 0) ? sb7 : sq_sb[k-1];
      end
    end
  end

  // stage A: scale by distance; stage B: add rounding half
  sb_t         sbA, sbB;
  logic [54:0] prodxA, prodyA;
  logic [36:0] len50A;
  logic [37:0] len100A, denB;
  logic [55:0] numxB, numyB;

  always_ff @(posedge clk) begin
    if (en) begin
      sbA     <= sq_sb[SQ_LAT-1];
      prodxA  <= 55'(sq_sb[SQ_LAT-1].abxn) * 55'(dist_root[24:0]);
      prodyA  <= 55'(sq_sb[SQ_LAT-1].abyn) * 55'(dist_root[24:0]);
      len50A  <= 37'(len_root) * 37'd50;
      len100A <= 38'(len_root) * 38'd100;
      sbB     <= sbA;
      numxB   <= 56'(prodxA) + 56'(len50A);
      numyB   <= 56'(prodyA) + 56'(len50A);
      denB    <= len100A;
    end
  end

  logic [DV_LAT-1:0] qx, qy;

  psk_div #(.NW(56), .DW(38), .QW(DV_LAT)) u_div_x (
    .clk (clk),
    .en  (en),
    .num (numxB),
    .den (denB),
    .quo (qx)
  );

  psk_div #(.NW(56), .DW(38), .QW(DV_LAT)) u_div_y (
    .clk (clk),
    .en  (en),
    .num (numyB),
    .den (denB),
    .quo (qy)
  );

  sb_t dv_sb [DV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DV_LAT; k++) begin
        dv_sb[k] <= (k == 0) ? sbB : dv_sb[k-1];
      end
    end
  end

  // result assembly
  sb_t                       sbz;
  psk_out_t                  res;
  logic signed [FIELD_W-1:0] nvx, nvy;

  assign sbz = dv_sb[DV_LAT-1];

  always_comb begin
    if (sbz.zero) begin
      nvx = '0;
      nvy = '0;
    end else begin
      nvx = sbz.sx ? -FIELD_W'(qx) : FIELD_W'(qx);
      nvy = sbz.sy ? -FIELD_W'(qy) : FIELD_W'(qy);
    end
    if (sbz.hid) begin
      res.new_pos_x  = sbz.px;
      res.new_pos_y  = sbz.py;
      res.new_vel_x  = sbz.vx;
      res.new_vel_y  = sbz.vy;
      res.new_hidden = 1'b1;
    end else if (sbz.near) begin
      res.new_pos_x  = $signed(FIELD_W'(sbz.tx));
      res.new_pos_y  = $signed(FIELD_W'(sbz.ty));
      res.new_vel_x  = '0;
      res.new_vel_y  = '0;
      res.new_hidden = 1'b1;
    end else begin
      res.new_pos_x  = sat24(25'(sbz.px) + 25'(nvx));
      res.new_pos_y  = sat24(25'(sbz.py) + 25'(nvy));
      res.new_vel_x  = nvx;
      res.new_vel_y  = nvy;
      res.new_hidden = 1'b0;
    end
  end

  // output register with skid
  logic     out_vld;
  psk_out_t out_data, skid_data;
  logic     push;

  assign push = en && vld[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (out_vld && out_ch.ready) begin
      if (skid_vld) begin
        out_data <= skid_data;
        skid_vld <= 1'b0;
      end else if (push) begin
        out_data <= res;
      end else begin
        out_vld <= 1'b0;
      end
    end else if (!out_vld) begin
      if (push) begin
        out_data <= res;
        out_vld  <= 1'b1;
      end
    end else if (push) begin
      skid_data <= res;
      skid_vld  <= 1'b1;
    end
  end

  assign out_ch.valid = out_vld;
  assign out_ch.data  = out_data;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_vld)
    else $error("skid holds an item while output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_vld) |-> $past(out_vld && !out_ch.ready))
    else $error("skid filled without an output stall");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push |=> out_vld)
    else $error("item leaving the pipeline was dropped");
`endif

endmodule
`default_nettype wire

// File: sv/psk_isqrt.sv
`default_nettype none
module psk_isqrt #(
  parameter int W = 62
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [W-1:0]     rad,
  output logic      [W/2-1:0]   root
);
  localparam int RW   = W / 2;
  localparam int REMW = RW + 3;

  logic [W-1:0]    rad_q  [RW];
  logic [REMW-1:0] rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [W-1:0]    rad_next  [RW];
  logic [REMW-1:0] rem_next  [RW];
  logic [RW-1:0]   root_next [RW];

  // one result bit per stage, from the top
  always_comb begin
    logic [W-1:0]    rs;
    logic [REMW-1:0] rm;
    logic [REMW-1:0] tr;
    logic [RW-1:0]   rt;
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        rs = rad;
        rm = '0;
        rt = '0;
      end else begin
        rs = rad_q[k-1];
        rm = rem_q[k-1];
        rt = root_q[k-1];
      end
      rm = {rm[REMW-3:0], rs[W-1:W-2]};
      tr = REMW'({rt, 2'b01});
      if (rm >= tr) begin
        rm = rm - tr;
        rt = {rt[RW-2:0], 1'b1};
      end else begin
        rt = {rt[RW-2:0], 1'b0};
      end
      rad_next[k]  = rs << 2;
      rem_next[k]  = rm;
      root_next[k] = rt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RW; k++) begin
        rad_q[k]  <= rad_next[k];
        rem_q[k]  <= rem_next[k];
        root_q[k] <= root_next[k];
      end
    end
  end

  assign root = root_q[RW-1];

endmodule
`default_nettype wire

// File: sv/psk_div.sv
`default_nettype none
module psk_div #(
  parameter int NW = 56,
  parameter int DW = 38,
  parameter int QW = 19
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [QW-1:0] quo
);
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [CW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [CW-1:0] rem_next [QW];
  logic [QW-1:0] quo_next [QW];

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [CW-1:0] rm;
    logic [CW-1:0] sub;
    logic [DW-1:0] dd;
    logic [QW-1:0] qq;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rm = CW'(num);
        dd = den;
        qq = '0;
      end else begin
        rm = rem_q[k-1];
        dd = den_q[k-1];
        qq = quo_q[k-1];
      end
      sub = CW'(dd) << (QW - 1 - k);
      if (rm >= sub) begin
        rm = rm - sub;
        qq = {qq[QW-2:0], 1'b1};
      end else begin
        qq = {qq[QW-2:0], 1'b0};
      end
      rem_next[k] = rm;
      quo_next[k] = qq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_q[k] <= rem_next[k];
        quo_q[k] <= quo_next[k];
        den_q[k] <= (k == 0) ? den : den_q[k-1];
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule
`default_nettype wire
